### design/scpd_pkg.sv
// ============================================================================
// Sine commutation PWM duty package
// Shared types, register codes and fixed-point constants for the three-phase
// sinusoidal commutation duty generator.
// ============================================================================
package scpd_pkg;

	// Encoder resolution. The phase arithmetic assumes a power of two.
	localparam int ENCODER_COUNTS = 4096;
	localparam int ENC_BITS       = $clog2(ENCODER_COUNTS);
	localparam int ANG_SHIFT      = 32 - ENC_BITS;

	// Default fraction bits of the sine, handed down as a module parameter.
	localparam int DEF_SINE_FRAC_BITS = 15;

	// Binary angle offsets of one and two thirds of a turn (floor of 2^32/3, 2^33/3).
	localparam logic [31:0] ONE_THIRD_TURN  = 32'h5555_5555;
	localparam logic [31:0] TWO_THIRDS_TURN = 32'hAAAA_AAAA;

	// Q30 constants of the sine series.
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [31:0] PI_Q30  = 32'hC90F_DAA2;

	// Series divisors (2k)(2k+1), innermost first, sine through x^13.
	localparam int HORNER_STEPS = 6;
	localparam logic [7:0] SERIES_DIV [0:HORNER_STEPS-1] = '{
		8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
	};

	// Duty scaling: the scaled quotient fits in 21 bits, the duty in 18.
	localparam int          DUTY_DIV   = 10;
	localparam int          WQ_BITS    = 21;
	localparam int          DQ_BITS    = 18;
	localparam int          RECIP_BITS = 18;
	localparam logic [RECIP_BITS-1:0] DUTY_RECIP = RECIP_BITS'((64'd1 << WQ_BITS) / DUTY_DIV);

	// Pipeline depth of one lane and of the whole block.
	localparam int LANE_LATENCY = 3 + 3 * HORNER_STEPS + 8;
	localparam int ITEM_LATENCY = 2 + LANE_LATENCY;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 4;
	localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_OFFSET = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_POLE_PAIRS   = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PWM_PERIOD   = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DUTY_CLAMP   = 4'd3;

	// Register values after reset.
	localparam logic [11:0] RST_ANGLE_OFFSET = 12'd0;
	localparam logic [5:0]  RST_POLE_PAIRS   = 6'd7;
	localparam logic [15:0] RST_PWM_PERIOD   = 16'd1000;
	localparam logic [15:0] RST_DUTY_CLAMP   = 16'd950;

	// Input item.
	typedef struct packed {
		logic [11:0]        encoder_count;
		logic signed [15:0] drive_voltage;
	} in_t;

	// Result item.
	typedef struct packed {
		logic [15:0] duty_a;
		logic [15:0] duty_b;
		logic [15:0] duty_c;
	} out_t;

	// Duty settings handed to each lane.
	typedef struct packed {
		logic [15:0] pwm_period;
		logic [15:0] duty_clamp;
	} duty_cfg_t;

	// Values carried alongside the series evaluation.
	typedef struct packed {
		logic [31:0]        x2;
		logic [30:0]        x;
		logic               neg;
		logic signed [15:0] volts;
	} side_t;

endpackage

### design/scpd_lane.sv
// ============================================================================
// Sine commutation duty lane
// Turns one 32-bit binary angle and a drive voltage into a clamped PWM
// compare value: quadrant fold, Q30 Taylor series by Horner steps, rounding,
// voltage scaling and an exact divide by ten times the unit.
// ============================================================================
module scpd_lane #(
	parameter int SINE_FRAC_BITS = scpd_pkg::DEF_SINE_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [31:0]           angle,
	input  logic signed [15:0]    volts,
	input  scpd_pkg::duty_cfg_t   cfg,
	output logic                  out_valid,
	output logic [15:0]           duty
);
	import scpd_pkg::*;

	localparam int SINE_W     = SINE_FRAC_BITS + 2;
	localparam int VS_W       = SINE_FRAC_BITS + 18;
	localparam int NUM_W      = VS_W + 17;
	localparam int DUTY_SHIFT = 11 + SINE_FRAC_BITS;
	localparam logic [31:0]        RND_HALF  = 32'(64'd1 << (29 - SINE_FRAC_BITS));
	localparam logic [SINE_W-1:0]  SINE_ONE  = SINE_W'(64'd1 << SINE_FRAC_BITS);
	localparam logic signed [VS_W-1:0] FIVE_U = VS_W'(64'd5 << DUTY_SHIFT);

	// Front stages: fold, radians, square.
	logic [30:0]        t_s1;
	logic               neg_s1, neg_s2;
	logic signed [15:0] volt_s1, volt_s2;
	logic [30:0]        x_s2;
	side_t              side_s3;
	logic               vld_s1, vld_s2, vld_s3;
	logic [62:0]        x_prod;
	logic [61:0]        x_sq;

	// Horner steps, three stages each.
	logic [30:0] term_in [0:HORNER_STEPS];
	side_t       side_in [0:HORNER_STEPS];
	logic        vld_in  [0:HORNER_STEPS];
	logic [31:0] h_prod_s1 [0:HORNER_STEPS-1];
	side_t       h_side_s1 [0:HORNER_STEPS-1];
	logic        h_vld_s1  [0:HORNER_STEPS-1];
	logic [31:0] h_quot_s2 [0:HORNER_STEPS-1];
	logic [31:0] h_prod_s2 [0:HORNER_STEPS-1];
	side_t       h_side_s2 [0:HORNER_STEPS-1];
	logic        h_vld_s2  [0:HORNER_STEPS-1];
	logic [30:0] h_term_s3 [0:HORNER_STEPS-1];
	side_t       h_side_s3 [0:HORNER_STEPS-1];
	logic        h_vld_s3  [0:HORNER_STEPS-1];

	// Back stages: sine rounding and duty scaling.
	logic [61:0]               s_prod;
	logic [30:0]               s_raw_s22;
	logic                      neg_s22;
	logic signed [15:0]        volt_s22, volt_s23;
	logic [31:0]               s_rnd;
	logic [SINE_W-1:0]         s_mag;
	logic [SINE_W-1:0]         s_lim;
	logic signed [SINE_W-1:0]  sine_s23;
	logic signed [VS_W-1:0]    vs_s24;
	logic signed [VS_W-1:0]    inner_s25;
	logic signed [NUM_W-1:0]   num_s26;
	logic [WQ_BITS-1:0]        w_cur;
	logic [WQ_BITS+RECIP_BITS-1:0] w_prod;
	logic [WQ_BITS-1:0]        w_s27;
	logic [DQ_BITS-1:0]        q0_s27;
	logic                      neg_s27;
	logic [WQ_BITS-1:0]        w_rem;
	logic [DQ_BITS-1:0]        dq_s28;
	logic [15:0]               duty_s29;
	logic vld_s22, vld_s23, vld_s24, vld_s25, vld_s26, vld_s27, vld_s28, vld_s29;

	// Front stage arithmetic.
	assign x_prod = t_s1 * PI_Q30;
	assign x_sq   = x_s2 * x_s2;

	always_ff @(posedge clk) begin
		if (angle[30]) begin
			t_s1 <= Q30_ONE - {1'b0, angle[29:0]};
		end else begin
			t_s1 <= {1'b0, angle[29:0]};
		end
		neg_s1        <= angle[31];
		volt_s1       <= volts;
		x_s2          <= x_prod[61:31];
		neg_s2        <= neg_s1;
		volt_s2       <= volt_s1;
		side_s3.x2    <= x_sq[61:30];
		side_s3.x     <= x_s2;
		side_s3.neg   <= neg_s2;
		side_s3.volts <= volt_s2;
	end

	assign term_in[0] = Q30_ONE;
	assign side_in[0] = side_s3;
	assign vld_in[0]  = vld_s3;

	// Each step: term = 1 - floor(floor(x2*term / 2^30) / d), the divide done as
	// a reciprocal multiply that may come out one low, then a remainder fix.
	for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
		localparam logic [7:0]  DIV   = SERIES_DIV[i];
		localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SERIES_DIV[i]);
		logic [62:0] prod;
		logic [63:0] qprod;
		logic [31:0] q_mul;
		logic [31:0] rem;
		logic [31:0] q_fix;

		assign prod  = side_in[i].x2 * term_in[i];
		assign qprod = h_prod_s1[i] * RECIP;
		assign q_mul = h_quot_s2[i] * 32'(DIV);
		assign rem   = h_prod_s2[i] - q_mul;
		assign q_fix = (rem >= 32'(DIV)) ? (h_quot_s2[i] + 32'd1) : h_quot_s2[i];

		always_ff @(posedge clk) begin
			h_prod_s1[i] <= prod[61:30];
			h_side_s1[i] <= side_in[i];
			h_quot_s2[i] <= qprod[63:32];
			h_prod_s2[i] <= h_prod_s1[i];
			h_side_s2[i] <= h_side_s1[i];
			h_term_s3[i] <= Q30_ONE - q_fix[30:0];
			h_side_s3[i] <= h_side_s2[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				h_vld_s1[i] <= 1'b0;
				h_vld_s2[i] <= 1'b0;
				h_vld_s3[i] <= 1'b0;
			end else begin
				h_vld_s1[i] <= vld_in[i];
				h_vld_s2[i] <= h_vld_s1[i];
				h_vld_s3[i] <= h_vld_s2[i];
			end
		end

		assign term_in[i+1] = h_term_s3[i];
		assign side_in[i+1] = h_side_s3[i];
		assign vld_in[i+1]  = h_vld_s3[i];
	end

	// Sine: final multiply by x, round half up, limit to one, apply quadrant sign.
	assign s_prod = side_in[HORNER_STEPS].x * term_in[HORNER_STEPS];
	assign s_rnd  = {1'b0, s_raw_s22} + RND_HALF;
	assign s_mag  = s_rnd[31:30-SINE_FRAC_BITS];
	assign s_lim  = (s_mag > SINE_ONE) ? SINE_ONE : s_mag;

	// Duty quotient: floor of the scaled numerator over ten, one low at most.
	assign w_cur  = num_s26[DUTY_SHIFT +: WQ_BITS];
	assign w_prod = w_cur * DUTY_RECIP;
	assign w_rem  = w_s27 - (WQ_BITS'(q0_s27) * WQ_BITS'(DUTY_DIV));

	always_ff @(posedge clk) begin
		s_raw_s22 <= s_prod[60:30];
		neg_s22   <= side_in[HORNER_STEPS].neg;
		volt_s22  <= side_in[HORNER_STEPS].volts;
		sine_s23  <= neg_s22 ? -$signed(s_lim) : $signed(s_lim);
		volt_s23  <= volt_s22;
		vs_s24    <= $signed(volt_s23) * $signed(sine_s23);
		inner_s25 <= vs_s24 + FIVE_U;
		num_s26   <= $signed({1'b0, cfg.pwm_period}) * inner_s25;
		w_s27     <= w_cur;
		q0_s27    <= w_prod[WQ_BITS+RECIP_BITS-1:WQ_BITS];
		neg_s27   <= num_s26[NUM_W-1];
		if (neg_s27) begin
			dq_s28 <= '0;
		end else if (w_rem >= WQ_BITS'(DUTY_DIV)) begin
			dq_s28 <= q0_s27 + DQ_BITS'(1);
		end else begin
			dq_s28 <= q0_s27;
		end
		if (dq_s28 > DQ_BITS'(cfg.duty_clamp)) begin
			duty_s29 <= cfg.duty_clamp;
		end else begin
			duty_s29 <= dq_s28[15:0];
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s22 <= 1'b0;
			vld_s23 <= 1'b0;
			vld_s24 <= 1'b0;
			vld_s25 <= 1'b0;
			vld_s26 <= 1'b0;
			vld_s27 <= 1'b0;
			vld_s28 <= 1'b0;
			vld_s29 <= 1'b0;
		end else begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s22 <= vld_in[HORNER_STEPS];
			vld_s23 <= vld_s22;
			vld_s24 <= vld_s23;
			vld_s25 <= vld_s24;
			vld_s26 <= vld_s25;
			vld_s27 <= vld_s26;
			vld_s28 <= vld_s27;
			vld_s29 <= vld_s28;
		end
	end

	assign out_valid = vld_s29;
	assign duty      = duty_s29;

endmodule

### design/sine_commutation_pwm_duty.sv
// ============================================================================
// Three-phase sinusoidal commutation PWM duty generator
// Encoder position and drive voltage in, three clamped compare values out.
// ============================================================================
// An item is taken at every clock edge where start is high; busy never rises,
// so a new item may follow in every cycle. Each item gives one result, shown
// on result for the single cycle in which done is high; the receiver cannot
// hold results off. Two stages form the electrical angle and the three phase
// angles, then each per-phase lane spends 3 stages on folding and squaring,
// 18 on the six Horner steps of the sine series (multiply, reciprocal
// multiply, remainder fix), and 8 on rounding and scaling the duty. cfg_ready
// is always high; registers must be written only while no item is in
// flight, since the later stages read them directly.
module sine_commutation_pwm_duty #(
	parameter int SINE_FRAC_BITS = scpd_pkg::DEF_SINE_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  scpd_pkg::in_t                     cmd,
	output logic                              done,
	output scpd_pkg::out_t                    result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [scpd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [15:0]                       cfg_data
);
	import scpd_pkg::*;

	logic [11:0]        angle_offset_q;
	logic [5:0]         pole_pairs_q;
	logic [15:0]        pwm_period_q;
	logic [15:0]        duty_clamp_q;
	duty_cfg_t          lane_cfg;

	logic [12:0]        pos_sum;
	logic [18:0]        elec_prod;
	logic [ENC_BITS-1:0] elec_s1;
	logic signed [15:0] volt_s1, volt_s2;
	logic               vld_s1, vld_s2;
	logic [31:0]        ang_base;
	logic [31:0]        ang_a_s2, ang_b_s2, ang_c_s2;

	logic               vld_a, vld_b, vld_c;
	logic [15:0]        duty_a, duty_b, duty_c;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_offset_q <= RST_ANGLE_OFFSET;
			pole_pairs_q   <= RST_POLE_PAIRS;
			pwm_period_q   <= RST_PWM_PERIOD;
			duty_clamp_q   <= RST_DUTY_CLAMP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ANGLE_OFFSET: angle_offset_q <= cfg_data[11:0];
				CFG_POLE_PAIRS:   pole_pairs_q   <= cfg_data[5:0];
				CFG_PWM_PERIOD:   pwm_period_q   <= cfg_data;
				CFG_DUTY_CLAMP:   duty_clamp_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign lane_cfg.pwm_period = pwm_period_q;
	assign lane_cfg.duty_clamp = duty_clamp_q;

	// Electrical angle: offset position times pole pairs, modulo the resolution.
	assign pos_sum   = 13'(cmd.encoder_count) + 13'(angle_offset_q);
	assign elec_prod = pos_sum * pole_pairs_q;
	assign ang_base  = 32'(elec_s1) << ANG_SHIFT;

	// Phase angles: B lags a third of a turn, C leads a third.
	always_ff @(posedge clk) begin
		elec_s1  <= elec_prod[ENC_BITS-1:0];
		volt_s1  <= cmd.drive_voltage;
		ang_a_s2 <= ang_base;
		ang_b_s2 <= ang_base + TWO_THIRDS_TURN;
		ang_c_s2 <= ang_base + ONE_THIRD_TURN;
		volt_s2  <= volt_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	// One lane per phase.
	scpd_lane #(
		.SINE_FRAC_BITS(SINE_FRAC_BITS)
	) u_lane_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.angle     (ang_a_s2),
		.volts     (volt_s2),
		.cfg       (lane_cfg),
		.out_valid (vld_a),
		.duty      (duty_a)
	);

	scpd_lane #(
		.SINE_FRAC_BITS(SINE_FRAC_BITS)
	) u_lane_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.angle     (ang_b_s2),
		.volts     (volt_s2),
		.cfg       (lane_cfg),
		.out_valid (vld_b),
		.duty      (duty_b)
	);

	scpd_lane #(
		.SINE_FRAC_BITS(SINE_FRAC_BITS)
	) u_lane_c (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.angle     (ang_c_s2),
		.volts     (volt_s2),
		.cfg       (lane_cfg),
		.out_valid (vld_c),
		.duty      (duty_c)
	);

	assign done          = vld_a;
	assign result.duty_a = duty_a;
	assign result.duty_b = duty_b;
	assign result.duty_c = duty_c;

`ifndef SYNTHESIS
	// Every result comes from an item taken a fixed latency earlier.
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, ITEM_LATENCY))
		else $error("result without a matching item");

	// Every item taken gives a result after the fixed latency.
	a_item_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##ITEM_LATENCY done)
		else $error("item lost in the pipeline");

	// The three phase lanes stay in lockstep.
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_a == vld_b) && (vld_a == vld_c))
		else $error("phase lanes out of step");

	// A pole pair write lands in the register.
	a_pole_pairs_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == CFG_POLE_PAIRS)
		|=> (pole_pairs_q == $past(cfg_data[5:0])))
		else $error("pole pair write not taken");
`endif

endmodule
